// File: rtl/core/hvt_pkg.sv
// shared constants for the homogeneous vertex transform
package hvt_pkg;

	localparam int unsigned COEF_W    = 16;
	localparam int unsigned COEF_FRAC = 12;
	localparam int unsigned OUT_FRAC  = 16;
	localparam int unsigned NUM_ROWS  = 4;
	localparam int unsigned NUM_COLS  = 4;
	localparam int unsigned NUM_LANES = 3;
	localparam int unsigned W_COL     = 3;
	localparam int unsigned ROW_W     = 64;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_3 = 3'd3;

	localparam logic [ROW_W-1:0] ROW_0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [ROW_W-1:0] ROW_3_RESET = 64'h1000_0000_0000_0000;

endpackage

// File: rtl/core/homogeneous_vertex_transform.sv
// top level: 4x4 vertex transform with perspective divide, Q16.16 in and out
// datapath order: product stage, sum stage, queue, operand setup, divide stages, output register
// throughput: one vertex per cycle when the output is not stalled; set by the bit-per-stage divide pipeline
// front and back stall separately through a two-entry queue
// reset clears all valid state and loads the identity matrix
module homogeneous_vertex_transform #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hvt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hvt_pkg::ROW_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_WIDTH-1:0]      in_x,
	input  logic signed [COORD_WIDTH-1:0]      in_y,
	input  logic signed [COORD_WIDTH-1:0]      in_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z,
	output logic                               w_was_zero,
	output logic                               saturated
);

	localparam int unsigned QW = 4 * (COORD_WIDTH + 17) + 5;

	logic [hvt_pkg::ROW_W-1:0] row_q [hvt_pkg::NUM_ROWS];
	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= hvt_pkg::ROW_0_RESET;
			row_q[1] <= hvt_pkg::ROW_1_RESET;
			row_q[2] <= hvt_pkg::ROW_2_RESET;
			row_q[3] <= hvt_pkg::ROW_3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hvt_pkg::REG_ROW_0: row_q[0] <= cfg_data;
				hvt_pkg::REG_ROW_1: row_q[1] <= cfg_data;
				hvt_pkg::REG_ROW_2: row_q[2] <= cfg_data;
				hvt_pkg::REG_ROW_3: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	hvt_front #(.CW(COORD_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.rows       (row_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hvt_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hvt_back #(.CW(COORD_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.w_was_zero (w_was_zero),
		.saturated  (saturated)
	);

endmodule

// File: rtl/core/hvt_front.sv
// front end: matrix products, column sums and zero-w classification
module hvt_front #(
	parameter int unsigned CW = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [CW-1:0]           in_x,
	input  logic signed [CW-1:0]           in_y,
	input  logic signed [CW-1:0]           in_z,
	input  logic [hvt_pkg::ROW_W-1:0]      rows [hvt_pkg::NUM_ROWS],
	output logic                           push_valid,
	input  logic                           push_ready,
	output logic [4*(CW+17)+4:0]           push_data
);

	localparam int unsigned PW   = CW + 16;
	localparam int unsigned SW   = CW + 18;
	localparam int unsigned MAGW = CW + 17;

	logic                 adv;
	logic                 v_s1, v_s2;
	logic signed [PW-1:0] p_s1 [hvt_pkg::NUM_LANES][hvt_pkg::NUM_COLS];
	logic signed [hvt_pkg::COEF_W-1:0] t_s1 [hvt_pkg::NUM_COLS];
	logic [MAGW-1:0]      mag_s2 [hvt_pkg::NUM_COLS];
	logic                 neg_s2 [hvt_pkg::NUM_COLS];
	logic                 wz_s2;
	logic signed [CW-1:0] vin [hvt_pkg::NUM_LANES];
	logic signed [SW-1:0] sum [hvt_pkg::NUM_COLS];

	assign vin[0] = in_x;
	assign vin[1] = in_y;
	assign vin[2] = in_z;

	assign adv        = !v_s2 || push_ready;
	assign in_ready   = adv;
	assign push_valid = v_s2;

	always_comb begin
		for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
			sum[c] = SW'(p_s1[0][c]) + SW'(p_s1[1][c]) + SW'(p_s1[2][c])
				+ (SW'(t_s1[c]) <<< hvt_pkg::OUT_FRAC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
				for (int r = 0; r < hvt_pkg::NUM_LANES; r++) begin
					p_s1[r][c] <= vin[r] *
						$signed(rows[r][hvt_pkg::COEF_W*c +: hvt_pkg::COEF_W]);
				end
				t_s1[c] <= $signed(rows[hvt_pkg::W_COL][hvt_pkg::COEF_W*c +: hvt_pkg::COEF_W]);
				neg_s2[c] <= sum[c][SW-1];
				mag_s2[c] <= sum[c][SW-1] ? MAGW'(-sum[c]) : MAGW'(sum[c]);
			end
			wz_s2 <= (sum[hvt_pkg::W_COL] == '0);
		end
	end

	always_comb begin
		push_data = '0;
		for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
			push_data[c*MAGW +: MAGW] = mag_s2[c];
			push_data[4*MAGW + c]     = neg_s2[c];
		end
		push_data[4*MAGW + 4] = wz_s2;
	end

endmodule

// File: rtl/core/hvt_queue.sv
// two-entry queue between front and back end
module hvt_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/core/hvt_back.sv
// back end: pipelined perspective divide, saturation and output register
module hvt_back #(
	parameter int unsigned CW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  logic [4*(CW+17)+4:0]  pop_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [CW-1:0]  out_x,
	output logic signed [CW-1:0]  out_y,
	output logic signed [CW-1:0]  out_z,
	output logic                  w_was_zero,
	output logic                  saturated
);

	localparam int unsigned MAGW = CW + 17;
	localparam int unsigned MW   = MAGW - hvt_pkg::COEF_FRAC;
	localparam int unsigned NL   = hvt_pkg::NUM_LANES;

	logic adv;

	logic            v_s   [CW+1];
	logic            wz_s  [CW+1];
	logic [MAGW-1:0] d_s   [CW+1];
	logic [MAGW-1:0] rem_s [CW+1][NL];
	logic [CW-1:0]   low_s [CW+1][NL];
	logic [CW-1:0]   q_s   [CW+1][NL];
	logic            ovf_s [CW+1][NL];
	logic            neg_s [CW+1][NL];
	logic [MW-1:0]   zm_s  [CW+1][NL];

	logic [MAGW-1:0] in_mag [hvt_pkg::NUM_COLS];
	logic            in_neg [hvt_pkg::NUM_COLS];
	logic            in_wz;
	logic [MAGW-1:0] hi     [NL];

	logic [MW-1:0]   fmag [NL];
	logic [MW-1:0]   lim  [NL];
	logic [CW-1:0]   fval [NL];
	logic            fsat;

	assign adv       = !out_valid || out_ready;
	assign pop_ready = adv;

	always_comb begin
		for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
			in_mag[c] = pop_data[c*MAGW +: MAGW];
			in_neg[c] = pop_data[4*MAGW + c];
		end
		in_wz = pop_data[4*MAGW + 4];
		for (int l = 0; l < NL; l++) begin
			hi[l] = in_mag[l] >> (CW - hvt_pkg::OUT_FRAC);
		end
	end

	// operand setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_s[0] <= in_wz;
			d_s[0]  <= in_mag[hvt_pkg::W_COL];
			for (int l = 0; l < NL; l++) begin
				rem_s[0][l] <= hi[l];
				low_s[0][l] <= CW'({in_mag[l], {hvt_pkg::OUT_FRAC{1'b0}}});
				q_s[0][l]   <= '0;
				ovf_s[0][l] <= (hi[l] >= in_mag[hvt_pkg::W_COL]);
				neg_s[0][l] <= in_wz ? in_neg[l] : (in_neg[l] ^ in_neg[hvt_pkg::W_COL]);
				zm_s[0][l]  <= MW'(in_mag[l] >> hvt_pkg::COEF_FRAC);
			end
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < CW; k++) begin : g_div
		logic [MAGW:0] trial [NL];

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				trial[l] = {rem_s[k][l], low_s[k][l][CW-1]} - {1'b0, d_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				wz_s[k+1] <= wz_s[k];
				d_s[k+1]  <= d_s[k];
				for (int l = 0; l < NL; l++) begin
					if (!trial[l][MAGW]) begin
						rem_s[k+1][l] <= trial[l][MAGW-1:0];
						q_s[k+1][l]   <= {q_s[k][l][CW-2:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= {rem_s[k][l][MAGW-2:0], low_s[k][l][CW-1]};
						q_s[k+1][l]   <= {q_s[k][l][CW-2:0], 1'b0};
					end
					low_s[k+1][l] <= {low_s[k][l][CW-2:0], 1'b0};
					ovf_s[k+1][l] <= ovf_s[k][l];
					neg_s[k+1][l] <= neg_s[k][l];
					zm_s[k+1][l]  <= zm_s[k][l];
				end
			end
		end
	end

	// select and clamp
	always_comb begin
		fsat = 1'b0;
		for (int l = 0; l < NL; l++) begin
			if (wz_s[CW]) fmag[l] = zm_s[CW][l];
			else if (ovf_s[CW][l]) fmag[l] = MW'(1) << CW;
			else fmag[l] = MW'(q_s[CW][l]);
			lim[l] = neg_s[CW][l] ? (MW'(1) << (CW - 1)) : ((MW'(1) << (CW - 1)) - MW'(1));
			if (fmag[l] > lim[l]) begin
				fmag[l] = lim[l];
				fsat    = 1'b1;
			end
			fval[l] = neg_s[CW][l] ? CW'(-fmag[l]) : CW'(fmag[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x      <= fval[0];
			out_y      <= fval[1];
			out_z      <= fval[2];
			w_was_zero <= wz_s[CW];
			saturated  <= fsat;
		end
	end

endmodule
